[sv/gvi_pkg.sv]
// shared constants, codes, types and helpers of the grid velocity interpolator
package gvi_pkg;

    localparam int GRID_SIDE_MAX = 32;
    localparam int VALUE_WIDTH   = 32;
    localparam int COORD_BITS    = $clog2(GRID_SIDE_MAX);
    localparam int ADDR_BITS     = 3 * COORD_BITS;
    localparam int SIDE_BITS     = 6;
    localparam int FIELD_BITS    = 32;
    localparam int W_BITS        = 18;
    localparam int WXY_BITS      = 20;
    localparam int ACC_BITS      = 64;
    localparam int FRAC_BITS     = 16;
    localparam int MOD_BITS      = 33;

    localparam logic [1:0] KERNEL_COSINE = 2'd0;
    localparam logic [1:0] KERNEL_PESKIN = 2'd1;
    localparam logic [1:0] KERNEL_HAT    = 2'd2;
    localparam logic [1:0] DIM_3D        = 2'd3;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_INTERP = 1'b1;

    localparam logic [2:0] REG_DIMENSIONS    = 3'd0;
    localparam logic [2:0] REG_KERNEL_TYPE   = 3'd1;
    localparam logic [2:0] REG_GRID_CELLS_X  = 3'd2;
    localparam logic [2:0] REG_GRID_CELLS_Y  = 3'd3;
    localparam logic [2:0] REG_GRID_CELLS_Z  = 3'd4;
    localparam logic [2:0] REG_INV_SPACING_X = 3'd5;
    localparam logic [2:0] REG_INV_SPACING_Y = 3'd6;
    localparam logic [2:0] REG_INV_SPACING_Z = 3'd7;

    // sin(pi x / 2) odd polynomial, Q2.30, highest degree first
    localparam logic signed [32:0] SIN_COEF [5] = '{
        33'sd172272, -33'sd5026995, 33'sd85569306, -33'sd693598668, 33'sd1686629713
    };

    typedef enum logic [2:0] {
        AX_IDLE, AX_MUL, AX_PREP, AX_MOD, AX_SQ, AX_SQRT, AX_POLY, AX_DONE
    } ax_state_t;

    typedef enum logic [2:0] {
        T_IDLE, T_AXIS_GO, T_AXIS_WAIT, T_WALK, T_DRAIN, T_OUT
    } top_state_t;

    typedef struct packed {
        logic                   go;
        logic [1:0]             kernel;
        logic [SIDE_BITS-1:0]   n;
        logic [FIELD_BITS-1:0]  pos;
        logic [FIELD_BITS-1:0]  inv;
    } axis_req_t;

    typedef struct packed {
        logic                         done;
        logic [COORD_BITS-1:0]        start;
        logic [3:0][W_BITS-1:0]       w;
    } axis_rsp_t;

    function automatic logic [SIDE_BITS-1:0] side(input logic [SIDE_BITS-1:0] n);
        if (n == '0)
            return SIDE_BITS'(1);
        if (n > SIDE_BITS'(GRID_SIDE_MAX))
            return SIDE_BITS'(GRID_SIDE_MAX);
        return n;
    endfunction

endpackage

[sv/gvi_in_if.sv]
// query channel: grid writes and interpolation requests
interface gvi_in_if;
    import gvi_pkg::*;
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [ADDR_BITS-1:0]   cell_index;
    logic signed [31:0]     write_vel_x;
    logic signed [31:0]     write_vel_y;
    logic signed [31:0]     write_vel_z;
    logic signed [31:0]     pos_x;
    logic signed [31:0]     pos_y;
    logic signed [31:0]     pos_z;

    modport source (output valid, opcode, cell_index, write_vel_x, write_vel_y,
                    write_vel_z, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, opcode, cell_index, write_vel_x, write_vel_y,
                    write_vel_z, pos_x, pos_y, pos_z, output ready);
endinterface

[sv/gvi_out_if.sv]
// result channel: interpolated velocity
interface gvi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] interp_vel_x;
    logic signed [31:0] interp_vel_y;
    logic signed [31:0] interp_vel_z;
    logic               saturated;

    modport source (output valid, interp_vel_x, interp_vel_y, interp_vel_z, saturated,
                    input ready);
    modport sink   (input valid, interp_vel_x, interp_vel_y, interp_vel_z, saturated,
                    output ready);
endinterface

[sv/gvi_cfg_if.sv]
// configuration write channel
interface gvi_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[sv/grid_velocity_interp_at_point.sv]
// A write request stores one velocity vector. A query first runs each axis
// (two in 2D, three in 3D) through the axis unit one after the other: multiply and wrap
// remainder, then a square and square root for Peskin or the sine polynomial for cosine. Then
// the stencil (16 or 64 cells; 4 or 8 for hat) is read from the grid ram at one cell a
// cycle, and the pipeline then drains. An unknown kernel returns zero. Queries run one at a time.
module grid_velocity_interp_at_point (
    input  logic      clk,
    input  logic      rst_n,
    gvi_in_if.sink    query,
    gvi_out_if.source result,
    gvi_cfg_if.sink   cfg
);
    import gvi_pkg::*;

    localparam int RBITS = ACC_BITS - FRAC_BITS;
    localparam logic signed [RBITS-1:0] HI =
        {{(RBITS - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
    localparam logic signed [RBITS-1:0] LO = ~HI;

    top_state_t state_reg, state_next;

    logic [1:0]            dim_reg, kern_reg;
    logic [SIDE_BITS-1:0]  ncx_reg, ncy_reg, ncz_reg;
    logic [31:0]           invx_reg, invy_reg, invz_reg;
    logic [SIDE_BITS-1:0]  nx, ny, nz;
    logic                  three;

    logic [31:0]           posx_reg, posy_reg, posz_reg;
    logic [1:0]            ax_reg;
    logic [3:0][W_BITS-1:0] wx_reg, wy_reg, wz_reg;
    logic [COORD_BITS-1:0] gx0_reg, gy0_reg;
    logic [COORD_BITS-1:0] gx_reg, gy_reg, gz_reg;
    logic [1:0]            i_reg, j_reg, k_reg;

    logic                  v1_reg, v2_reg, v3_reg;
    logic [COORD_BITS-1:0] gx1_reg;
    logic [ADDR_BITS:0]    yz1_reg;
    logic signed [WXY_BITS-1:0] wxy1_reg, w2_reg;
    logic [1:0]            k1_reg;
    logic signed [51:0]    px_reg, py_reg, pz_reg;
    logic signed [ACC_BITS-1:0] accx_reg, accy_reg, accz_reg;

    logic                  out_valid_reg;
    logic [31:0]           outx_reg, outy_reg, outz_reg;
    logic                  outsat_reg;

    logic                  q_acc, is_write, walk_emit, out_load, axis_go;
    logic [1:0]            last_ax, cnt_last;
    logic                  last_i, last_j, last_k;
    axis_req_t             areq;
    axis_rsp_t             arsp;
    logic [3*FIELD_BITS-1:0] rdata;
    logic [ADDR_BITS:0]    yz_c, addr_c;
    logic signed [35:0]    wxy_full;
    logic signed [37:0]    wz_full;
    logic [RBITS:0]        clx, cly, clz;

    function automatic logic [COORD_BITS-1:0] wrap_inc(input logic [COORD_BITS-1:0] g,
                                                      input logic [SIDE_BITS-1:0] n);
        if (SIDE_BITS'(g) + SIDE_BITS'(1) == n)
            return '0;
        return g + COORD_BITS'(1);
    endfunction

    // returns {clipped flag, floored and clipped value}
    function automatic logic [RBITS:0] clip(input logic signed [ACC_BITS-1:0] acc);
        logic signed [RBITS-1:0] r;
        r = acc[ACC_BITS-1:FRAC_BITS];
        if (r > HI)
            return {1'b1, HI};
        if (r < LO)
            return {1'b1, LO};
        return {1'b0, r};
    endfunction

    assign nx = side(ncx_reg);
    assign ny = side(ncy_reg);
    assign nz = side(ncz_reg);
    assign three = (dim_reg == DIM_3D);

    assign q_acc    = query.valid && query.ready;
    assign is_write = (query.opcode == OP_WRITE);
    assign last_ax  = three ? 2'd2 : 2'd1;
    assign cnt_last = (kern_reg == KERNEL_HAT) ? 2'd1 : 2'd3;
    assign last_i   = (i_reg == cnt_last);
    assign last_j   = (j_reg == cnt_last);
    assign last_k   = !three || (k_reg == cnt_last);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_IDLE:
            begin
                if (q_acc && !is_write)
                    state_next = (kern_reg == 2'd3) ? T_OUT : T_AXIS_GO;
            end
            T_AXIS_GO:   state_next = T_AXIS_WAIT;
            T_AXIS_WAIT:
            begin
                if (arsp.done)
                    state_next = (ax_reg == last_ax) ? T_WALK : T_AXIS_GO;
            end
            T_WALK:      if (last_i && last_j && last_k) state_next = T_DRAIN;
            T_DRAIN:     if (!v1_reg && !v2_reg && !v3_reg) state_next = T_OUT;
            T_OUT:       if (!out_valid_reg || result.ready) state_next = T_IDLE;
            default:     state_next = T_IDLE;
        endcase
    end

    always_comb
    begin
        query.ready = (state_reg == T_IDLE);
        axis_go     = (state_reg == T_AXIS_GO);
        walk_emit   = (state_reg == T_WALK);
        out_load    = (state_reg == T_OUT) && (!out_valid_reg || result.ready);
    end

    always_comb
    begin
        areq.go     = axis_go;
        areq.kernel = kern_reg;
        case (ax_reg)
            2'd0:
            begin
                areq.n = nx; areq.pos = posx_reg; areq.inv = invx_reg;
            end
            2'd1:
            begin
                areq.n = ny; areq.pos = posy_reg; areq.inv = invy_reg;
            end
            default:
            begin
                areq.n = nz; areq.pos = posz_reg; areq.inv = invz_reg;
            end
        endcase
    end

    gvi_axis u_axis (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (areq),
        .rsp   (arsp)
    );

    assign yz_c   = (ADDR_BITS+1)'(gy_reg) + (ADDR_BITS+1)'(ny) * (ADDR_BITS+1)'(gz_reg);
    assign addr_c = (ADDR_BITS+1)'(gx1_reg) + (ADDR_BITS+1)'(nx) * yz1_reg;
    assign wxy_full = $signed(wx_reg[i_reg]) * $signed(wy_reg[j_reg]);
    assign wz_full  = wxy1_reg * $signed(wz_reg[k1_reg]);

    gvi_ram #(
        .WIDTH (3 * FIELD_BITS),
        .DEPTH (1 << ADDR_BITS)
    ) u_grid (
        .clk   (clk),
        .we    (q_acc && is_write),
        .waddr (query.cell_index),
        .wdata ({query.write_vel_z, query.write_vel_y, query.write_vel_x}),
        .raddr (addr_c[ADDR_BITS-1:0]),
        .rdata (rdata)
    );

    assign clx = clip(accx_reg);
    assign cly = clip(accy_reg);
    assign clz = clip(accz_reg);

    // configuration port
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg  <= 2'd2;
            kern_reg <= KERNEL_PESKIN;
            ncx_reg  <= SIDE_BITS'(32);
            ncy_reg  <= SIDE_BITS'(32);
            ncz_reg  <= SIDE_BITS'(1);
            invx_reg <= 32'd2097152;
            invy_reg <= 32'd2097152;
            invz_reg <= 32'd2097152;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_DIMENSIONS:    dim_reg  <= cfg.data[1:0];
                REG_KERNEL_TYPE:   kern_reg <= cfg.data[1:0];
                REG_GRID_CELLS_X:  ncx_reg  <= cfg.data[SIDE_BITS-1:0];
                REG_GRID_CELLS_Y:  ncy_reg  <= cfg.data[SIDE_BITS-1:0];
                REG_GRID_CELLS_Z:  ncz_reg  <= cfg.data[SIDE_BITS-1:0];
                REG_INV_SPACING_X: invx_reg <= cfg.data;
                REG_INV_SPACING_Y: invy_reg <= cfg.data;
                REG_INV_SPACING_Z: invz_reg <= cfg.data;
                default:           dim_reg  <= dim_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v1_reg    <= walk_emit;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_acc && !is_write)
        begin
            posx_reg <= query.pos_x;
            posy_reg <= query.pos_y;
            posz_reg <= query.pos_z;
            ax_reg   <= '0;
            accx_reg <= '0;
            accy_reg <= '0;
            accz_reg <= '0;
            i_reg    <= '0;
            j_reg    <= '0;
            k_reg    <= '0;
            gz_reg   <= '0;
            // 2D: one plane, unit weight along z
            wz_reg   <= {{(3 * W_BITS){1'b0}}, W_BITS'(1 << FRAC_BITS)};
        end

        if (state_reg == T_AXIS_WAIT && arsp.done)
        begin
            ax_reg <= ax_reg + 2'd1;
            case (ax_reg)
                2'd0:
                begin
                    wx_reg <= arsp.w; gx0_reg <= arsp.start; gx_reg <= arsp.start;
                end
                2'd1:
                begin
                    wy_reg <= arsp.w; gy0_reg <= arsp.start; gy_reg <= arsp.start;
                end
                default:
                begin
                    wz_reg <= arsp.w; gz_reg <= arsp.start;
                end
            endcase
        end

        if (walk_emit)
        begin
            if (!last_i)
            begin
                i_reg  <= i_reg + 2'd1;
                gx_reg <= wrap_inc(gx_reg, nx);
            end
            else
            begin
                i_reg  <= '0;
                gx_reg <= gx0_reg;
                if (!last_j)
                begin
                    j_reg  <= j_reg + 2'd1;
                    gy_reg <= wrap_inc(gy_reg, ny);
                end
                else
                begin
                    j_reg  <= '0;
                    gy_reg <= gy0_reg;
                    k_reg  <= k_reg + 2'd1;
                    gz_reg <= wrap_inc(gz_reg, nz);
                end
            end
        end

        // stage 1: row offset and xy weight
        gx1_reg  <= gx_reg;
        yz1_reg  <= yz_c;
        wxy1_reg <= wxy_full[16+WXY_BITS-1:16];
        k1_reg   <= k_reg;

        // stage 2: ram read in flight, z weight applied
        w2_reg <= three ? wz_full[16+WXY_BITS-1:16] : wxy1_reg;

        // stage 3: weighted velocities
        px_reg <= $signed(rdata[FIELD_BITS-1:0]) * w2_reg;
        py_reg <= $signed(rdata[2*FIELD_BITS-1:FIELD_BITS]) * w2_reg;
        pz_reg <= three ? $signed(rdata[3*FIELD_BITS-1:2*FIELD_BITS]) * w2_reg : 52'sd0;

        // stage 4: accumulate
        if (v3_reg)
        begin
            accx_reg <= accx_reg + ACC_BITS'(px_reg);
            accy_reg <= accy_reg + ACC_BITS'(py_reg);
            accz_reg <= accz_reg + ACC_BITS'(pz_reg);
        end

        if (out_load)
        begin
            outx_reg   <= clx[31:0];
            outy_reg   <= cly[31:0];
            outz_reg   <= clz[31:0];
            outsat_reg <= clx[RBITS] | cly[RBITS] | clz[RBITS];
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.interp_vel_x = outx_reg;
    assign result.interp_vel_y = outy_reg;
    assign result.interp_vel_z = outz_reg;
    assign result.saturated    = outsat_reg;
endmodule

[sv/gvi_ram.sv]
// generic single-port-write, registered-read ram
module gvi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[sv/gvi_axis.sv]
// per-axis unit: grid coordinate, wrapped stencil start and kernel weights
module gvi_axis (
    input  logic                clk,
    input  logic                rst_n,
    input  gvi_pkg::axis_req_t  req,
    output gvi_pkg::axis_rsp_t  rsp
);
    import gvi_pkg::*;

    ax_state_t state_reg, state_next;

    logic [1:0]              kern_reg;
    logic [SIDE_BITS-1:0]    n_reg;
    logic [FIELD_BITS-1:0]   pos_reg, inv_reg;
    logic signed [31:0]      base_reg;
    logic [15:0]             f_reg;
    logic                    neg_reg;
    logic [MOD_BITS-1:0]     a_reg;
    logic [COORD_BITS-1:0]   rem_reg;
    logic [5:0]              cnt_reg;
    logic [34:0]             v_reg, res_reg;
    logic [16:0]             x_reg, x2_reg, s_reg, c_reg;
    logic signed [32:0]      p_reg;
    logic                    eval_reg;
    logic                    done_reg;
    logic [COORD_BITS-1:0]   start_reg;
    logic [3:0][W_BITS-1:0]  w_reg;

    logic signed [32:0]      mul_a, mul_b;
    logic signed [65:0]      mul_p;
    logic signed [MOD_BITS-1:0] sb;
    logic [COORD_BITS:0]     sh, sh_red;
    logic [34:0]             bitv, sum;
    logic signed [35:0]      pr;
    logic [16:0]             clamped;
    logic [34:0]             q;
    logic signed [20:0]      pk [4];
    logic signed [18:0]      ck [4];

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            AX_IDLE: if (req.go) state_next = AX_MUL;
            AX_MUL:  state_next = AX_PREP;
            AX_PREP: state_next = AX_MOD;
            AX_MOD:
            begin
                if (cnt_reg == 6'(MOD_BITS - 1))
                begin
                    case (kern_reg)
                        KERNEL_PESKIN: state_next = AX_SQ;
                        KERNEL_COSINE: state_next = AX_POLY;
                        default:       state_next = AX_DONE;
                    endcase
                end
            end
            AX_SQ:   state_next = AX_SQRT;
            AX_SQRT: if (cnt_reg == 6'd17) state_next = AX_DONE;
            AX_POLY: if (cnt_reg == 6'd5 && eval_reg) state_next = AX_DONE;
            AX_DONE: state_next = AX_IDLE;
            default: state_next = AX_IDLE;
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            AX_MUL:
            begin
                mul_a = {pos_reg[31], pos_reg};
                mul_b = {1'b0, inv_reg};
            end
            AX_SQ:
            begin
                mul_a = {17'b0, f_reg};
                mul_b = {17'b0, f_reg};
            end
            AX_POLY:
            begin
                if (cnt_reg == 6'd0)
                begin
                    mul_a = {16'b0, x_reg};
                    mul_b = {16'b0, x_reg};
                end
                else if (cnt_reg == 6'd5)
                begin
                    mul_a = p_reg;
                    mul_b = {16'b0, x_reg};
                end
                else
                begin
                    mul_a = p_reg;
                    mul_b = {16'b0, x2_reg};
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        if (kern_reg == KERNEL_COSINE || kern_reg == KERNEL_PESKIN)
            sb = {base_reg[31], base_reg} - MOD_BITS'(1);
        else
            sb = {base_reg[31], base_reg};

        sh = {rem_reg, a_reg[MOD_BITS-1]};
        sh_red = (sh >= n_reg) ? sh - n_reg : sh;

        q = (35'd1 << 32) + ({19'b0, f_reg} << 18) - (mul_p[34:0] << 2);

        bitv = 35'd1 << (6'd34 - {cnt_reg[4:0], 1'b0});
        sum = res_reg + bitv;

        pr = mul_p[65:30];
        if (pr < 0)
            clamped = '0;
        else if (pr > 36'sd65536)
            clamped = 17'd65536;
        else
            clamped = pr[16:0];

        pk[0] = 21'sd196608 - 21'($signed({1'b0, f_reg, 1'b0})) - 21'($signed({1'b0, res_reg[16:0]}));
        pk[1] = 21'sd196608 - 21'($signed({1'b0, f_reg, 1'b0})) + 21'($signed({1'b0, res_reg[16:0]}));
        pk[2] = 21'sd65536 + 21'($signed({1'b0, f_reg, 1'b0})) + 21'($signed({1'b0, res_reg[16:0]}));
        pk[3] = 21'sd65536 + 21'($signed({1'b0, f_reg, 1'b0})) - 21'($signed({1'b0, res_reg[16:0]}));
        ck[0] = 19'sd65536 - 19'($signed({1'b0, s_reg}));
        ck[1] = 19'sd65536 + 19'($signed({1'b0, c_reg}));
        ck[2] = 19'sd65536 + 19'($signed({1'b0, s_reg}));
        ck[3] = 19'sd65536 - 19'($signed({1'b0, c_reg}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AX_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == AX_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            AX_IDLE:
            begin
                if (req.go)
                begin
                    kern_reg <= req.kernel;
                    n_reg    <= req.n;
                    pos_reg  <= req.pos;
                    inv_reg  <= req.inv;
                end
            end
            AX_MUL:
            begin
                base_reg <= mul_p[63:32];
                f_reg    <= mul_p[31:16];
            end
            AX_PREP:
            begin
                // negative start: remainder of -j-1, mirrored below
                neg_reg <= sb[MOD_BITS-1];
                a_reg   <= sb[MOD_BITS-1] ? ~sb : sb;
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            AX_MOD:
            begin
                rem_reg <= sh_red[COORD_BITS-1:0];
                a_reg   <= {a_reg[MOD_BITS-2:0], 1'b0};
                if (cnt_reg == 6'(MOD_BITS - 1))
                begin
                    start_reg <= neg_reg
                        ? COORD_BITS'(n_reg - SIDE_BITS'(1) - {1'b0, sh_red[COORD_BITS-1:0]})
                        : sh_red[COORD_BITS-1:0];
                    cnt_reg  <= '0;
                    x_reg    <= {1'b0, f_reg};
                    eval_reg <= 1'b0;
                    res_reg  <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                end
            end
            AX_SQ:
            begin
                v_reg   <= q;
                res_reg <= '0;
                cnt_reg <= '0;
            end
            AX_SQRT:
            begin
                if (v_reg >= sum)
                begin
                    v_reg   <= v_reg - sum;
                    res_reg <= (res_reg >> 1) + bitv;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                cnt_reg <= cnt_reg + 6'd1;
            end
            AX_POLY:
            begin
                if (cnt_reg == 6'd0)
                begin
                    x2_reg  <= mul_p[32:16];
                    p_reg   <= SIN_COEF[0];
                    cnt_reg <= 6'd1;
                end
                else if (cnt_reg == 6'd5)
                begin
                    if (eval_reg)
                    begin
                        c_reg <= clamped;
                    end
                    else
                    begin
                        s_reg    <= clamped;
                        x_reg    <= 17'd65536 - {1'b0, f_reg};
                        eval_reg <= 1'b1;
                    end
                    cnt_reg <= '0;
                end
                else
                begin
                    p_reg   <= SIN_COEF[cnt_reg[2:0]] + 33'(mul_p >>> 16);
                    cnt_reg <= cnt_reg + 6'd1;
                end
            end
            AX_DONE:
            begin
                case (kern_reg)
                    KERNEL_COSINE:
                    begin
                        for (int i = 0; i < 4; i++)
                            w_reg[i] <= W_BITS'(ck[i] >>> 2);
                    end
                    KERNEL_PESKIN:
                    begin
                        for (int i = 0; i < 4; i++)
                            w_reg[i] <= W_BITS'(pk[i] >>> 3);
                    end
                    KERNEL_HAT:
                    begin
                        w_reg[0] <= W_BITS'(18'd65536 - {2'b0, f_reg});
                        w_reg[1] <= W_BITS'(f_reg);
                        w_reg[2] <= '0;
                        w_reg[3] <= '0;
                    end
                    default:
                    begin
                        w_reg <= '0;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.done  = done_reg;
    assign rsp.start = start_reg;
    assign rsp.w     = w_reg;
endmodule
